FILE: sv/rbba_pkg.sv
// Shared types and constants for the rotated bounding box accumulator.
package rbba_pkg;

   localparam int NUM_SLOTS   = 12;
   localparam int COORD_W     = 32;
   localparam int BOUND_W     = 33;
   localparam int SLOT_IDX_W  = 4;
   localparam int THRESH_W    = 16;
   localparam int DIM_W       = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [DIM_W-1:0]    DIM_RESET    = 3'd3;
   localparam logic [THRESH_W-1:0] THRESH_RESET = '0;

   typedef logic signed [BOUND_W-1:0] bound_type;
   typedef bound_type slot_vec_type [NUM_SLOTS];
   typedef logic [SLOT_IDX_W-1:0] slot_idx_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DIMENSION       = 2'd0,
      CSR_NOISE_THRESHOLD = 2'd1
   } csr_index_type;

   // Control into the bound accumulator.
   typedef struct packed {
      logic                 update;
      logic                 last;
      logic [NUM_SLOTS-1:0] used;
   } acc_ctrl_type;

   // Control into the result buffer.
   typedef struct packed {
      logic         load;
      slot_idx_type count;
      logic         dim_one;
   } snap_ctrl_type;

endpackage

FILE: sv/rbba_ifs.sv
// Channel interfaces: vertex requests, slot results and register writes.
interface rbba_req_if import rbba_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] coord_x;
   logic signed [COORD_W-1:0] coord_y;
   logic signed [COORD_W-1:0] coord_z;
   logic signed [COORD_W-1:0] coord_w;
   logic                      last_vertex;

   modport source (output valid, coord_x, coord_y, coord_z, coord_w, last_vertex,
                   input ready);
   modport sink (input valid, coord_x, coord_y, coord_z, coord_w, last_vertex,
                 output ready);
endinterface

interface rbba_rsp_if import rbba_pkg::*;;
   logic         valid;
   logic         ready;
   slot_idx_type slot_index;
   bound_type    slot_min;
   bound_type    slot_max;
   logic         last_slot;

   modport source (output valid, slot_index, slot_min, slot_max, last_slot,
                   input ready);
   modport sink (input valid, slot_index, slot_min, slot_max, last_slot,
                 output ready);
endinterface

interface rbba_csr_if import rbba_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/rbba_slot_calc.sv
// Slot value generation: axis values and 45-degree rotated projections of one vertex.
module rbba_slot_calc import rbba_pkg::*; #(
   parameter int MAX_DIM   = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic [DIM_W-1:0]          dimension,
   input  logic signed [COORD_W-1:0] coord_x,
   input  logic signed [COORD_W-1:0] coord_y,
   input  logic signed [COORD_W-1:0] coord_z,
   input  logic signed [COORD_W-1:0] coord_w,
   output slot_vec_type              slot_val,
   output slot_idx_type              slot_count,
   output logic [NUM_SLOTS-1:0]      slot_used,
   output logic                      dim_one
);

   // 1/sqrt(2) in Q0.24, rounded to nearest at FRAC_BITS fraction bits
   localparam int K_Q24   = 11863283;
   localparam int ROT_K   = (((K_Q24 * 2) >> (24 - FRAC_BITS)) + 1) >> 1;
   localparam int PROD_W  = COORD_W + FRAC_BITS + 1;
   localparam int SUM_W   = PROD_W + 1;
   localparam int DIM_CAP = (MAX_DIM < 4) ? MAX_DIM : 4;
   localparam logic signed [FRAC_BITS:0] K_S = (FRAC_BITS + 1)'(ROT_K);

   logic signed [PROD_W-1:0] prod_x;
   logic signed [PROD_W-1:0] prod_y;
   logic signed [PROD_W-1:0] prod_z;
   bound_type                cx;
   bound_type                cy;
   bound_type                cz;
   bound_type                cw;
   logic [DIM_W-1:0]         eff_dim;

   // Sum or difference of two scaled coordinates, floored back to Q17.16.
   function automatic bound_type rot(input logic signed [PROD_W-1:0] pa,
                                     input logic signed [PROD_W-1:0] pb,
                                     input logic neg);
      logic signed [SUM_W-1:0] s;
      if (neg) begin
         s = SUM_W'(pa) - SUM_W'(pb);
      end else begin
         s = SUM_W'(pa) + SUM_W'(pb);
      end
      return BOUND_W'(s >>> FRAC_BITS);
   endfunction

   assign prod_x = PROD_W'(coord_x) * PROD_W'(K_S);
   assign prod_y = PROD_W'(coord_y) * PROD_W'(K_S);
   assign prod_z = PROD_W'(coord_z) * PROD_W'(K_S);

   assign cx = BOUND_W'(coord_x);
   assign cy = BOUND_W'(coord_y);
   assign cz = BOUND_W'(coord_z);
   assign cw = BOUND_W'(coord_w);

   // Zero acts as one; clamp at the supported coordinate count.
   always_comb begin
      eff_dim = dimension;
      if (eff_dim == '0) begin
         eff_dim = DIM_W'(1);
      end
      if (int'(eff_dim) > DIM_CAP) begin
         eff_dim = DIM_W'(DIM_CAP);
      end
   end

   assign dim_one = (eff_dim == DIM_W'(1));

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_val[i] = '0;
      end
      slot_used  = '0;
      slot_count = '0;
      unique case (eff_dim)
         3'd3: begin
            slot_val[0]  = cx;
            slot_val[1]  = cy;
            slot_val[2]  = cz;
            slot_val[3]  = cx;
            slot_val[4]  = rot(prod_y, prod_z, 1'b1);
            slot_val[5]  = rot(prod_y, prod_z, 1'b0);
            slot_val[6]  = rot(prod_x, prod_z, 1'b1);
            slot_val[7]  = cy;
            slot_val[8]  = rot(prod_x, prod_z, 1'b0);
            slot_val[9]  = rot(prod_x, prod_y, 1'b1);
            slot_val[10] = rot(prod_x, prod_y, 1'b0);
            slot_val[11] = cz;
            slot_used    = '1;
            slot_count   = SLOT_IDX_W'(NUM_SLOTS);
         end
         3'd2: begin
            slot_val[0] = cx;
            slot_val[1] = cy;
            slot_val[2] = rot(prod_x, prod_y, 1'b1);
            slot_val[3] = rot(prod_x, prod_y, 1'b0);
            slot_used   = NUM_SLOTS'(4'hf);
            slot_count  = SLOT_IDX_W'(4);
         end
         default: begin
            // plain box, one slot per coordinate
            slot_val[0] = cx;
            slot_used   = NUM_SLOTS'(1);
            slot_count  = SLOT_IDX_W'(1);
            if (eff_dim == DIM_W'(4)) begin
               slot_val[1] = cy;
               slot_val[2] = cz;
               slot_val[3] = cw;
               slot_used   = NUM_SLOTS'(4'hf);
               slot_count  = SLOT_IDX_W'(4);
            end
         end
      endcase
   end

endmodule

FILE: sv/rbba_bound_acc.sv
// Running per-slot minimum and maximum with first-vertex initialization.
module rbba_bound_acc import rbba_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  acc_ctrl_type ctrl,
   input  slot_vec_type slot_val,
   output slot_vec_type bound_min_in,
   output slot_vec_type bound_max_in
);

   slot_vec_type bound_min_ff;
   slot_vec_type bound_max_ff;
   logic         first_ff;
   logic         first_in;

   always_comb begin
      first_in = first_ff;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         bound_min_in[i] = bound_min_ff[i];
         bound_max_in[i] = bound_max_ff[i];
      end
      if (ctrl.update) begin
         first_in = ctrl.last;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (first_ff) begin
               bound_min_in[i] = slot_val[i];
               bound_max_in[i] = slot_val[i];
            end else if (ctrl.used[i]) begin
               if (slot_val[i] < bound_min_ff[i]) begin
                  bound_min_in[i] = slot_val[i];
               end
               if (slot_val[i] > bound_max_ff[i]) begin
                  bound_max_in[i] = slot_val[i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else begin
         first_ff <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         bound_min_ff[i] <= bound_min_in[i];
         bound_max_ff[i] <= bound_max_in[i];
      end
   end

endmodule

FILE: sv/rbba_rsp_buf.sv
// Result buffer: holds one polygon's bounds and shifts them out one slot per transfer.
module rbba_rsp_buf import rbba_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  snap_ctrl_type       snap,
   input  logic [THRESH_W-1:0] noise_threshold,
   input  slot_vec_type        bound_min,
   input  slot_vec_type        bound_max,
   output logic                busy,
   rbba_rsp_if.source          rsp
);

   slot_vec_type buf_min_ff;
   slot_vec_type buf_max_ff;
   slot_idx_type idx_ff;
   slot_idx_type idx_in;
   slot_idx_type remain_ff;
   slot_idx_type remain_in;
   logic         xfer;

   // Force a bound of small magnitude to zero.
   function automatic bound_type squelch(input bound_type b,
                                         input logic [THRESH_W-1:0] thr);
      logic signed [BOUND_W:0] wide;
      logic [BOUND_W:0]        mag;
      wide = (BOUND_W + 1)'(b);
      if (wide < 0) begin
         wide = -wide;
      end
      mag = wide[BOUND_W:0];
      if (mag < (BOUND_W + 1)'(thr)) begin
         return '0;
      end
      return b;
   endfunction

   assign xfer           = rsp.valid && rsp.ready;
   assign busy           = (remain_ff != '0);
   assign rsp.valid      = (remain_ff != '0);
   assign rsp.slot_index = idx_ff;
   assign rsp.slot_min   = buf_min_ff[0];
   assign rsp.slot_max   = buf_max_ff[0];
   assign rsp.last_slot  = (remain_ff == SLOT_IDX_W'(1));

   always_comb begin
      idx_in    = idx_ff;
      remain_in = remain_ff;
      if (snap.load) begin
         idx_in    = '0;
         remain_in = snap.count;
      end else if (xfer) begin
         idx_in    = idx_ff + SLOT_IDX_W'(1);
         remain_in = remain_ff - SLOT_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         remain_ff <= '0;
      end else begin
         idx_ff    <= idx_in;
         remain_ff <= remain_in;
      end
   end

   // Only a one-coordinate box has its single slot squelched.
   always_ff @(posedge clock) begin
      if (snap.load) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            buf_min_ff[i] <= bound_min[i];
            buf_max_ff[i] <= bound_max[i];
         end
         if (snap.dim_one) begin
            buf_min_ff[0] <= squelch(bound_min[0], noise_threshold);
            buf_max_ff[0] <= squelch(bound_max[0], noise_threshold);
         end
      end else if (xfer) begin
         for (int i = 0; i < NUM_SLOTS - 1; i++) begin
            buf_min_ff[i] <= buf_min_ff[i + 1];
            buf_max_ff[i] <= buf_max_ff[i + 1];
         end
      end
   end

endmodule

FILE: sv/rotated_bounding_box_accumulator_unit.sv
// Top level of the rotated bounding box accumulator: vertex pipeline, bounds and results.
//
// Vertices of a control polygon arrive on req_if, one per transfer, with coordinates in
// signed Q16.16, and the block folds each into a running minimum and maximum per bound
// slot: 12 slots in dimension 3 (axes plus 45-degree rotated projections), 4 in
// dimension 2 and one per coordinate otherwise. A vertex is taken every cycle while the
// slot register is not stalled. It passes through the input register, from which the
// three constant products and the rotated sums are formed, and then the slot register,
// from which the compare-and-select updates the bounds; results of a polygon start on
// rsp_if after its last vertex has passed both registers and its bounds are loaded into
// the result buffer, and follow one slot per transfer. The finished bounds move into that
// buffer, so the next polygon streams in while the previous one drains; only a further
// last vertex waits in the slot register until the buffer is empty. Registers are
// written on csr_if (index 0 dimension, index 1 noise threshold) and must change only
// while the block is idle.
module rotated_bounding_box_accumulator_unit import rbba_pkg::*; #(
   parameter int MAX_DIM   = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   rbba_req_if.sink  req_if,
   rbba_rsp_if.source rsp_if,
   rbba_csr_if.sink  csr_if
);

   // configuration registers
   logic [DIM_W-1:0]    dimension_ff;
   logic [DIM_W-1:0]    dimension_in;
   logic [THRESH_W-1:0] noise_ff;
   logic [THRESH_W-1:0] noise_in;

   // input register stage
   logic                      a_valid_ff;
   logic                      a_valid_in;
   logic signed [COORD_W-1:0] a_x_ff;
   logic signed [COORD_W-1:0] a_y_ff;
   logic signed [COORD_W-1:0] a_z_ff;
   logic signed [COORD_W-1:0] a_w_ff;
   logic                      a_last_ff;

   // slot register stage
   logic                 b_valid_ff;
   logic                 b_valid_in;
   slot_vec_type         b_val_ff;
   slot_idx_type         b_count_ff;
   logic [NUM_SLOTS-1:0] b_used_ff;
   logic                 b_dim_one_ff;
   logic                 b_last_ff;

   slot_vec_type         calc_val;
   slot_idx_type         calc_count;
   logic [NUM_SLOTS-1:0] calc_used;
   logic                 calc_dim_one;

   slot_vec_type  bound_min_in;
   slot_vec_type  bound_max_in;
   acc_ctrl_type  acc_ctrl;
   snap_ctrl_type snap_ctrl;
   logic          rsp_busy;
   logic          stall_b;
   logic          b_load;
   logic          req_xfer;
   logic          csr_xfer;

   // ---------------------------------------------------------------------------------
   // Register writes; always ready, writes beyond the register list are dropped.
   // ---------------------------------------------------------------------------------
   assign csr_if.ready = 1'b1;
   assign csr_xfer     = csr_if.valid && csr_if.ready;

   always_comb begin
      dimension_in = dimension_ff;
      noise_in     = noise_ff;
      if (csr_xfer) begin
         unique case (csr_if.index)
            CSR_DIMENSION:       dimension_in = csr_if.data[DIM_W-1:0];
            CSR_NOISE_THRESHOLD: noise_in     = csr_if.data[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dimension_ff <= DIM_RESET;
         noise_ff     <= THRESH_RESET;
      end else begin
         dimension_ff <= dimension_in;
         noise_ff     <= noise_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Flow control. A last vertex in the slot register holds while the result buffer
   // still drains the previous polygon; everything behind it holds too.
   // ---------------------------------------------------------------------------------
   assign stall_b      = b_valid_ff && b_last_ff && rsp_busy;
   assign b_load       = a_valid_ff && !stall_b;
   assign req_if.ready = !a_valid_ff || !stall_b;
   assign req_xfer     = req_if.valid && req_if.ready;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_xfer) begin
         a_valid_in = 1'b1;
      end else if (b_load) begin
         a_valid_in = 1'b0;
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (b_load) begin
         b_valid_in = 1'b1;
      end else if (!stall_b) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   // capture the vertex
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         a_x_ff    <= req_if.coord_x;
         a_y_ff    <= req_if.coord_y;
         a_z_ff    <= req_if.coord_z;
         a_w_ff    <= req_if.coord_w;
         a_last_ff <= req_if.last_vertex;
      end
   end

   // ---------------------------------------------------------------------------------
   // Slot values from the registered vertex.
   // ---------------------------------------------------------------------------------
   rbba_slot_calc #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_slot_calc (
      .dimension  (dimension_ff),
      .coord_x    (a_x_ff),
      .coord_y    (a_y_ff),
      .coord_z    (a_z_ff),
      .coord_w    (a_w_ff),
      .slot_val   (calc_val),
      .slot_count (calc_count),
      .slot_used  (calc_used),
      .dim_one    (calc_dim_one)
   );

   always_ff @(posedge clock) begin
      if (b_load) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            b_val_ff[i] <= calc_val[i];
         end
         b_count_ff   <= calc_count;
         b_used_ff    <= calc_used;
         b_dim_one_ff <= calc_dim_one;
         b_last_ff    <= a_last_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // Fold the slot values into the bounds; on a last vertex, hand the updated bounds
   // to the result buffer in the same cycle.
   // ---------------------------------------------------------------------------------
   assign acc_ctrl.update = b_valid_ff && !stall_b;
   assign acc_ctrl.last   = b_last_ff;
   assign acc_ctrl.used   = b_used_ff;

   rbba_bound_acc u_bound_acc (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (acc_ctrl),
      .slot_val     (b_val_ff),
      .bound_min_in (bound_min_in),
      .bound_max_in (bound_max_in)
   );

   assign snap_ctrl.load    = acc_ctrl.update && b_last_ff;
   assign snap_ctrl.count   = b_count_ff;
   assign snap_ctrl.dim_one = b_dim_one_ff;

   rbba_rsp_buf u_rsp_buf (
      .clock           (clock),
      .reset           (reset),
      .snap            (snap_ctrl),
      .noise_threshold (noise_ff),
      .bound_min       (bound_min_in),
      .bound_max       (bound_max_in),
      .busy            (rsp_busy),
      .rsp             (rsp_if)
   );

endmodule
